// ===== design/vms_pkg.sv =====
// ----------------------------------------------------------------------------
// vms_pkg: shared types and constants
// Widths and stage types for the von Mises equivalent strain block.
// ----------------------------------------------------------------------------
`default_nettype none
package vms_pkg;
   localparam int FRAC_BITS = 24;
   localparam int DATA_WIDTH = 32;
   localparam int OUT_WIDTH = DATA_WIDTH - 1;
   localparam int TAG_WIDTH = 16;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;          // one product
   localparam int C_WIDTH = PROD_WIDTH + 2;              // sum of three products
   localparam int D_WIDTH = C_WIDTH + 1;                 // diagonal difference
   localparam int SUM_WIDTH = 2 * D_WIDTH + 4;           // S, unsigned
   localparam int SHIFT = 2 * FRAC_BITS + 2;
   localparam int ROOT_STAGES = OUT_WIDTH + 1;           // saturation test + bits

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [TAG_WIDTH-1:0] tag_type;
   typedef logic [SUM_WIDTH-1:0] sum_type;
   typedef logic [OUT_WIDTH:0] root_type;

   typedef struct packed {
      tag_type tag;
      data_type [8:0] f;
   } req_type;

   typedef struct packed {
      tag_type tag;
      logic [OUT_WIDTH-1:0] strain;
      logic sat;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/vms_if.sv =====
// ----------------------------------------------------------------------------
// vms_if: valid/ready channel
// Carries one payload with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none
interface vms_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/vms_lane.sv =====
// ----------------------------------------------------------------------------
// vms_lane: one entry of C = F^T F
// Three registered products of column pairs, then their registered sum.
// ----------------------------------------------------------------------------
`default_nettype none
module vms_lane (
   input  wire logic clock,
   input  wire logic enable,
   input  wire vms_pkg::data_type [2:0] col_a,
   input  wire vms_pkg::data_type [2:0] col_b,
   output logic signed [vms_pkg::C_WIDTH-1:0] c_ff
);
   import vms_pkg::*;
   logic signed [PROD_WIDTH-1:0] prod_ff [3];
   logic signed [C_WIDTH-1:0] c_in;

   assign c_in = C_WIDTH'(prod_ff[0]) + C_WIDTH'(prod_ff[1]) + C_WIDTH'(prod_ff[2]);

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) prod_ff[k] <= col_a[k] * col_b[k];
         c_ff <= c_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/vms_merge.sv =====
// ----------------------------------------------------------------------------
// vms_merge: combine the six C entries into S
// Differences, squares (split into halves), weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none
module vms_merge (
   input  wire logic clock,
   input  wire logic enable,
   input  wire logic signed [5:0][vms_pkg::C_WIDTH-1:0] c_in_all,
   output vms_pkg::sum_type sum_ff
);
   import vms_pkg::*;
   localparam int HW = (D_WIDTH + 1) / 2;
   // six magnitudes: three diagonal differences, three shears
   logic [D_WIDTH-1:0] mag_ff [6];
   logic [D_WIDTH-1:0] mag_in [6];
   logic signed [D_WIDTH-1:0] dv [6];
   // partial products: hi*hi, hi*lo, lo*lo per magnitude
   logic [2*HW-1:0] pp_ff [6][3];
   sum_type sq [6];
   sum_type sum_in;

   // element selects of the packed array are unsigned: sign-extend explicitly
   always_comb begin
      dv[0] = D_WIDTH'($signed(c_in_all[0])) - D_WIDTH'($signed(c_in_all[1]));
      dv[1] = D_WIDTH'($signed(c_in_all[1])) - D_WIDTH'($signed(c_in_all[2]));
      dv[2] = D_WIDTH'($signed(c_in_all[2])) - D_WIDTH'($signed(c_in_all[0]));
      dv[3] = D_WIDTH'($signed(c_in_all[3]));
      dv[4] = D_WIDTH'($signed(c_in_all[4]));
      dv[5] = D_WIDTH'($signed(c_in_all[5]));
      for (int i = 0; i < 6; i++) mag_in[i] = dv[i][D_WIDTH-1] ? D_WIDTH'(-dv[i]) : dv[i];
      for (int i = 0; i < 6; i++)
         sq[i] = (SUM_WIDTH'(pp_ff[i][0]) << (2 * HW)) + (SUM_WIDTH'(pp_ff[i][1]) << (HW + 1))
               + SUM_WIDTH'(pp_ff[i][2]);
      sum_in = sq[0] + sq[1] + sq[2] + ((sq[3] + sq[4] + sq[5]) << 1)
             + ((sq[3] + sq[4] + sq[5]) << 2);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 6; i++) begin
            mag_ff[i] <= mag_in[i];
            pp_ff[i][0] <= (2*HW)'(mag_ff[i][D_WIDTH-1:HW]) * (2*HW)'(mag_ff[i][D_WIDTH-1:HW]);
            pp_ff[i][1] <= (2*HW)'(mag_ff[i][D_WIDTH-1:HW]) * (2*HW)'(mag_ff[i][HW-1:0]);
            pp_ff[i][2] <= (2*HW)'(mag_ff[i][HW-1:0]) * (2*HW)'(mag_ff[i][HW-1:0]);
         end
         sum_ff <= sum_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/vms_root.sv =====
// ----------------------------------------------------------------------------
// vms_root: pipelined restoring square root
// One result bit per stage; remainders kept exact against S / 2^SHIFT / 3.
// ----------------------------------------------------------------------------
`default_nettype none
module vms_root (
   input  wire logic clock,
   input  wire logic enable,
   input  wire vms_pkg::sum_type sum,
   output vms_pkg::root_type root_ff
);
   import vms_pkg::*;
   // Test 3*2^SHIFT*(r + 2^b)^2 <= S incrementally: keep R = S - 3*2^SHIFT*r^2.
   sum_type rem_ff [ROOT_STAGES];
   root_type r_ff [ROOT_STAGES];
   sum_type rem_in [ROOT_STAGES];
   root_type r_in [ROOT_STAGES];
   logic [SUM_WIDTH+1:0] need [ROOT_STAGES];

   always_comb begin
      for (int s = 0; s < ROOT_STAGES; s++) begin
         // bit b = OUT_WIDTH - s; stage 0 tests 2^OUT_WIDTH (saturation)
         sum_type rp;
         root_type rv;
         rp = (s == 0) ? sum : rem_ff[s-1];
         rv = (s == 0) ? '0 : r_ff[s-1];
         need[s] = (((SUM_WIDTH+2)'(rv) << (OUT_WIDTH - s + 1))
                  + ((SUM_WIDTH+2)'(1) << (2 * (OUT_WIDTH - s)))) * 3;
         need[s] = need[s] << SHIFT;
         if (need[s] <= (SUM_WIDTH+2)'(rp)) begin
            rem_in[s] = rp - SUM_WIDTH'(need[s]);
            r_in[s] = rv | ((OUT_WIDTH+1)'(1) << (OUT_WIDTH - s));
         end else begin
            rem_in[s] = rp;
            r_in[s] = rv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < ROOT_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            r_ff[s] <= r_in[s];
         end
      end
   end

   assign root_ff = r_ff[ROOT_STAGES-1];
endmodule
`default_nettype wire

// ===== design/von_mises_strain_from_deformation_unit.sv =====
// ----------------------------------------------------------------------------
// von_mises_strain_from_deformation_unit: von Mises strain per particle
// F^T F lanes, merge of differences and shears, pipelined square root.
// ----------------------------------------------------------------------------
// One 3x3 deformation gradient is taken every cycle while the pipe is not
// stalled; its result reaches rsp through 2 lane registers, 3 merge
// registers, 32 root stages and the output register, the first lane register
// loading at the accepting edge.
// The whole pipe advances when the output register is empty or being drained,
// so a stall on the rsp side holds everything without losing a transfer. The
// strain is the floor of the exact value in Q7.24 and saturates with the flag
// set.
`default_nettype none
module von_mises_strain_from_deformation_unit (
   input  wire logic clock,
   input  wire logic reset,
   vms_if.sink   req,
   vms_if.source rsp
);
   import vms_pkg::*;
   localparam int LAT = 2 + 3 + ROOT_STAGES;   // lane, merge, root stages

   logic enable;
   logic [LAT-1:0] vld_ff;
   tag_type tag_ff [LAT];
   req_type rq;
   logic signed [5:0][C_WIDTH-1:0] c_all;
   sum_type sum;
   root_type root;
   rsp_type out_ff;
   logic out_vld_ff;

   assign rq = req.payload;
   // pipe moves when the output slot is free or being taken
   assign enable = !out_vld_ff || rsp.ready;
   assign req.ready = enable;

   // lanes: C00 C11 C22 C01 C12 C02
   localparam int LA [6] = '{0, 1, 2, 0, 1, 0};
   localparam int LB [6] = '{0, 1, 2, 1, 2, 2};
   for (genvar l = 0; l < 6; l++) begin : g_lane
      vms_lane u_lane (
         .clock(clock), .enable(enable),
         .col_a('{rq.f[8 - (6 + LA[l])], rq.f[8 - (3 + LA[l])], rq.f[8 - LA[l]]}),
         .col_b('{rq.f[8 - (6 + LB[l])], rq.f[8 - (3 + LB[l])], rq.f[8 - LB[l]]}),
         .c_ff(c_all[l])
      );
   end

   vms_merge u_merge (.clock(clock), .enable(enable), .c_in_all(c_all), .sum_ff(sum));
   vms_root u_root (.clock(clock), .enable(enable), .sum(sum), .root_ff(root));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (enable) begin
            vld_ff <= {vld_ff[LAT-2:0], req.valid};
            out_vld_ff <= vld_ff[LAT-1];
         end
      end
      if (enable) begin
         tag_ff[0] <= rq.tag;
         for (int i = 1; i < LAT; i++) tag_ff[i] <= tag_ff[i-1];
         out_ff.tag <= tag_ff[LAT-1];
         out_ff.sat <= root[OUT_WIDTH];
         out_ff.strain <= root[OUT_WIDTH] ? '1 : root[OUT_WIDTH-1:0];
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire
